[hw/rtl/terminal_cursor_color_command_encoder_top_defines.svh]
// Assertion macros shared by the checker of the terminal command encoder.
// No dependencies; included by the files that hold assertions.
`ifndef TERMINAL_CURSOR_COLOR_COMMAND_ENCODER_TOP_DEFINES_SVH
`define TERMINAL_CURSOR_COLOR_COMMAND_ENCODER_TOP_DEFINES_SVH

// Checks a property at every rising edge, disabled while reset is applied.
`define TCCCE_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tccce assertion failed");

// Checks a property at every rising edge, reset included.
`define TCCCE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("tccce assertion failed");

`endif

[hw/rtl/tccce_pkg.sv]
// Package of the terminal command encoder: widths, command codes and word types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tccce_pkg;

    localparam int MAX_COLUMNS = 4096;
    localparam int MAX_ROWS    = 4096;
    localparam int RANGE_W     = 17;

    localparam int COL_W   = 12;
    localparam int ROW_W   = 12;
    localparam int COLOR_W = 8;
    localparam int GLYPH_W = 8;
    localparam int ARG_W   = 13;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_CELL  = 1'b1;

    localparam int MASK_W   = 5;
    localparam int BIT_MOVE = 0;
    localparam int BIT_RST  = 1;
    localparam int BIT_FG   = 2;
    localparam int BIT_BG   = 3;
    localparam int BIT_CHAR = 4;

    typedef enum logic [3:0] {
        CMD_RESET = 4'd0,
        CMD_POS   = 4'd1,
        CMD_FWD   = 4'd2,
        CMD_BACK  = 4'd3,
        CMD_DOWN  = 4'd4,
        CMD_UP    = 4'd5,
        CMD_FG    = 4'd6,
        CMD_BG    = 4'd7,
        CMD_CHAR  = 4'd8
    } cmd_t;

    typedef struct packed {
        logic                 kind;
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
        logic [COLOR_W-1:0]   fg_color;
        logic [COLOR_W-1:0]   bg_color;
        logic [GLYPH_W-1:0]   glyph;
    } in_t;

    typedef struct packed {
        cmd_t                 command;
        logic [ARG_W-1:0]     arg_a;
        logic [ARG_W-1:0]     arg_b;
        logic                 last;
    } out_t;

    typedef struct packed {
        cmd_t                 move_cmd;
        logic [ARG_W-1:0]     move_a;
        logic [ARG_W-1:0]     move_b;
        logic [COLOR_W-1:0]   fg;
        logic [COLOR_W-1:0]   bg;
        logic [GLYPH_W-1:0]   glyph;
        logic [MASK_W-1:0]    mask;
    } plan_t;

endpackage

[hw/rtl/tccce_front.sv]
// Front end: accepts words, tracks cursor and colours, and builds a command plan.
// Depends on tccce_pkg.
`timescale 1ns / 1ps

module tccce_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  tccce_pkg::in_t   item,
    input  logic             q_full,
    output logic             q_push,
    output tccce_pkg::plan_t q_plan
);
    import tccce_pkg::*;

    logic [ARG_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               known_reg, known_next;
    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;

    logic               accept;
    logic               in_range;
    logic               visible;
    logic               color_diff;
    logic               color_rst;
    logic [COLOR_W-1:0] base_fg;
    logic [COLOR_W-1:0] base_bg;
    logic signed [ARG_W:0]   dx;
    logic signed [ROW_W:0]   dy;

    assign full = q_full;

    always_comb
    begin
        accept   = push && !q_full;
        in_range = (RANGE_W'(item.col) < RANGE_W'(MAX_COLUMNS))
                && (RANGE_W'(item.row) < RANGE_W'(MAX_ROWS));
        visible  = (item.kind == KIND_CELL) && (item.glyph != '0) && in_range;
        dx = $signed({2'b00, item.col}) - $signed({1'b0, col_reg});
        dy = $signed({1'b0, item.row}) - $signed({1'b0, row_reg});

        color_diff = (item.fg_color != fg_reg) || (item.bg_color != bg_reg);
        color_rst  = color_diff && ((item.fg_color == '0) || (item.bg_color != '0));
        base_fg    = color_rst ? '0 : fg_reg;
        base_bg    = color_rst ? '0 : bg_reg;

        q_plan          = '0;
        q_plan.move_cmd = CMD_POS;
        q_plan.fg       = item.fg_color;
        q_plan.bg       = item.bg_color;
        q_plan.glyph    = item.glyph;

        if (item.kind == KIND_FRAME)
        begin
            q_plan.mask[BIT_RST] = 1'b1;
        end
        else
        begin
            q_plan.mask[BIT_MOVE] = 1'b1;
            if (!known_reg || ((dx != 0) && (dy != 0)))
            begin
                q_plan.move_cmd = CMD_POS;
                q_plan.move_a   = {1'b0, item.col} + ARG_W'(1);
                q_plan.move_b   = {1'b0, item.row} + ARG_W'(1);
            end
            else if (dx > 0)
            begin
                q_plan.move_cmd = CMD_FWD;
                q_plan.move_a   = ARG_W'(dx);
            end
            else if (dx < 0)
            begin
                q_plan.move_cmd = CMD_BACK;
                q_plan.move_a   = ARG_W'(-dx);
            end
            else if (dy > 0)
            begin
                q_plan.move_cmd = CMD_DOWN;
                q_plan.move_a   = ARG_W'(dy);
            end
            else if (dy < 0)
            begin
                q_plan.move_cmd = CMD_UP;
                q_plan.move_a   = ARG_W'(-dy);
            end
            else
            begin
                q_plan.mask[BIT_MOVE] = 1'b0;
            end
            q_plan.mask[BIT_RST]  = color_rst;
            q_plan.mask[BIT_FG]   = color_diff && (item.fg_color != base_fg);
            q_plan.mask[BIT_BG]   = color_diff && (item.bg_color != base_bg);
            q_plan.mask[BIT_CHAR] = 1'b1;
        end

        q_push = accept && ((item.kind == KIND_FRAME) || visible);

        col_next   = col_reg;
        row_next   = row_reg;
        known_next = known_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        if (accept && (item.kind == KIND_FRAME))
        begin
            col_next   = '0;
            row_next   = '0;
            known_next = 1'b0;
            fg_next    = '0;
            bg_next    = '0;
        end
        else if (accept && visible)
        begin
            col_next   = {1'b0, item.col} + ARG_W'(1);
            row_next   = item.row;
            known_next = 1'b1;
            fg_next    = item.fg_color;
            bg_next    = item.bg_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            known_reg <= 1'b0;
            fg_reg    <= '0;
            bg_reg    <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            known_reg <= known_next;
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
        end
    end

endmodule

[hw/rtl/tccce_queue.sv]
// Short plan queue between the front end and the command sequencer.
// Depends on tccce_pkg.
`timescale 1ns / 1ps

module tccce_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  tccce_pkg::plan_t wr_data,
    output logic             q_full,
    input  logic             rd_en,
    output logic             rd_valid,
    output tccce_pkg::plan_t rd_data
);
    import tccce_pkg::*;

    plan_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    always_comb
    begin
        q_full   = (count_reg == QCNT_W'(QUEUE_DEPTH));
        rd_valid = (count_reg != '0);
        rd_data  = mem_reg[rd_ptr_reg];
        do_wr    = wr_en && !q_full;
        do_rd    = rd_en && rd_valid;

        wr_ptr_next = wr_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_W'(1);
        end
        rd_ptr_next = rd_ptr_reg;
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_W'(1);
        end
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/tccce_back.sv]
// Sequencer: steps a plan into the result register a command per cycle unless stalled.
// Depends on tccce_pkg.
`timescale 1ns / 1ps

module tccce_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  tccce_pkg::plan_t q_data,
    output logic             q_pop,
    output logic             empty,
    input  logic             pop,
    output tccce_pkg::out_t  result
);
    import tccce_pkg::*;

    plan_t             plan_reg, plan_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic              out_valid_reg, out_valid_next;
    out_t              out_reg, out_next;

    logic              cur_valid;
    logic              out_free;
    logic              emit;
    logic [MASK_W-1:0] sel;
    logic [MASK_W-1:0] remaining;
    out_t              word;

    always_comb
    begin
        cur_valid = (mask_reg != '0);
        out_free  = !out_valid_reg || pop;
        emit      = cur_valid && out_free;

        sel  = '0;
        word = '0;
        word.command = CMD_CHAR;
        if (mask_reg[BIT_MOVE])
        begin
            sel[BIT_MOVE] = 1'b1;
            word.command  = plan_reg.move_cmd;
            word.arg_a    = plan_reg.move_a;
            word.arg_b    = plan_reg.move_b;
        end
        else if (mask_reg[BIT_RST])
        begin
            sel[BIT_RST] = 1'b1;
            word.command = CMD_RESET;
        end
        else if (mask_reg[BIT_FG])
        begin
            sel[BIT_FG]  = 1'b1;
            word.command = CMD_FG;
            word.arg_a   = ARG_W'(plan_reg.fg);
        end
        else if (mask_reg[BIT_BG])
        begin
            sel[BIT_BG]  = 1'b1;
            word.command = CMD_BG;
            word.arg_a   = ARG_W'(plan_reg.bg);
        end
        else
        begin
            sel[BIT_CHAR] = mask_reg[BIT_CHAR];
            word.command  = CMD_CHAR;
            word.arg_a    = ARG_W'(plan_reg.glyph);
        end
        remaining = mask_reg & ~sel;
        word.last = (remaining == '0);

        q_pop = q_valid && (!cur_valid || (emit && (remaining == '0)));

        plan_next = plan_reg;
        mask_next = mask_reg;
        if (q_pop)
        begin
            plan_next = q_data;
            mask_next = q_data.mask;
        end
        else if (emit)
        begin
            mask_next = remaining;
        end

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_next       = word;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end

        empty  = !out_valid_reg;
        result = out_reg;
    end

    always_ff @(posedge clk)
    begin
        plan_reg <= plan_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/terminal_cursor_color_command_encoder_top.sv]
// Top level of the terminal cursor and colour command encoder.
// Depends on tccce_pkg, tccce_front, tccce_queue and tccce_back.
//
// Channel   Handshake          Word
// input     push / full        item   (tccce_pkg::in_t)
// result    empty / pop        result (tccce_pkg::out_t)
//
// A word is taken in every cycle while the plan queue has room; the front end
// resolves cursor and colour state in that same cycle.
// The sequencer sends one command per cycle while the result is not stalled; a word
// causes 0 to 5 commands, none for a cell that is not drawn; typical cells take one.
// Reset clears the tracked cursor, colours, queue and result valid flag at once.
// A stalled result holds its word; the front end keeps accepting until the queue fills.
`timescale 1ns / 1ps

module terminal_cursor_color_command_encoder_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  tccce_pkg::in_t  item,
    output logic            empty,
    input  logic            pop,
    output tccce_pkg::out_t result
);
    import tccce_pkg::*;

    logic  q_full;
    logic  q_push;
    plan_t q_plan;
    logic  q_valid;
    plan_t q_head;
    logic  q_pop;

    tccce_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_plan (q_plan)
    );

    tccce_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_plan),
        .q_full   (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_head)
    );

    tccce_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_head),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

[hw/rtl/tccce_checker.sv]
// Port-level checker of the terminal command encoder, bound to the top level.
// Depends on tccce_pkg and the assertion macros of the defines header.
`timescale 1ns / 1ps
`include "terminal_cursor_color_command_encoder_top_defines.svh"

module tccce_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            push,
    input logic            full,
    input tccce_pkg::in_t  item,
    input logic            empty,
    input logic            pop,
    input tccce_pkg::out_t result
);
    import tccce_pkg::*;

    `TCCCE_ASSERT_RST(a_stall_holds, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(result)))
    `TCCCE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> empty)
    `TCCCE_ASSERT_RST(a_argb_pos_only, clk, rst_n, (!empty && result.command != CMD_POS) |-> (result.arg_b == '0))
    `TCCCE_ASSERT_RST(a_char_is_last, clk, rst_n, (!empty && result.last) |-> (result.command == CMD_CHAR || result.command == CMD_RESET))

endmodule

bind terminal_cursor_color_command_encoder_top tccce_checker u_tccce_checker (.*);

[dv/terminal_cursor_color_command_encoder_top_test.sv]
// Self-checking testbench of the terminal cursor and colour command encoder.
// Drives screen cells and frame starts, predicts the command words and checks each one.
// Depends on tccce_pkg and terminal_cursor_color_command_encoder_top.
`timescale 1ns / 1ps

module terminal_cursor_color_command_encoder_top_test;

    import tccce_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 32;
    localparam int CELL_COUNT  = 500;
    localparam int MAX_SHOWN   = 10;

    logic   clk   = 1'b0;
    logic   rst_n = 1'b0;
    logic   push  = 1'b0;
    logic   pop   = 1'b0;
    in_t    item  = '0;
    logic   full;
    logic   empty;
    out_t   result;

    in_t    cell_queue[$];
    out_t   pending_cmds[$];
    out_t   want;

    int     accepted_cells = 0;
    int     total_cells    = 0;
    int     drain_at_a     = -1;
    int     drain_at_b     = -1;
    int     mismatch_count = 0;
    int     stall_cycles   = 0;

    logic [12:0]        trk_col   = '0;
    logic [ROW_W-1:0]   trk_row   = '0;
    logic               trk_known = 1'b0;
    logic [COLOR_W-1:0] trk_fg    = '0;
    logic [COLOR_W-1:0] trk_bg    = '0;

    wire calm = (accepted_cells >= 200) && (accepted_cells < 300);

    terminal_cursor_color_command_encoder_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic in_t make_word(logic k, int c, int rw, int f, int b, int g);
        in_t w;
        w.kind     = k;
        w.col      = c[COL_W-1:0];
        w.row      = rw[ROW_W-1:0];
        w.fg_color = f[COLOR_W-1:0];
        w.bg_color = b[COLOR_W-1:0];
        w.glyph    = g[GLYPH_W-1:0];
        return w;
    endfunction

    function automatic void emit(cmd_t c, logic [ARG_W-1:0] a, logic [ARG_W-1:0] b, logic fin);
        out_t r;
        r.command = c;
        r.arg_a   = a;
        r.arg_b   = b;
        r.last    = fin;
        pending_cmds.push_back(r);
    endfunction

    function automatic void predict_commands(in_t w);
        int dx;
        int dy;
        if (w.kind == KIND_FRAME)
        begin
            trk_col   = '0;
            trk_row   = '0;
            trk_known = 1'b0;
            trk_fg    = '0;
            trk_bg    = '0;
            emit(CMD_RESET, '0, '0, 1'b1);
        end
        else if (w.glyph != 0 && int'(w.col) < MAX_COLUMNS && int'(w.row) < MAX_ROWS)
        begin
            dx = int'(w.col) - int'(trk_col);
            dy = int'(w.row) - int'(trk_row);
            if (!trk_known || (dx != 0 && dy != 0))
                emit(CMD_POS, {1'b0, w.col} + 13'd1, {1'b0, w.row} + 13'd1, 1'b0);
            else if (dx > 0)
                emit(CMD_FWD, 13'(dx), '0, 1'b0);
            else if (dx < 0)
                emit(CMD_BACK, 13'(-dx), '0, 1'b0);
            else if (dy > 0)
                emit(CMD_DOWN, 13'(dy), '0, 1'b0);
            else if (dy < 0)
                emit(CMD_UP, 13'(-dy), '0, 1'b0);
            trk_col   = {1'b0, w.col} + 13'd1;
            trk_row   = w.row;
            trk_known = 1'b1;
            if (w.fg_color != trk_fg || w.bg_color != trk_bg)
            begin
                if (w.fg_color == 0 || w.bg_color != 0)
                begin
                    emit(CMD_RESET, '0, '0, 1'b0);
                    trk_fg = '0;
                    trk_bg = '0;
                end
                if (w.fg_color != trk_fg)
                begin
                    trk_fg = w.fg_color;
                    emit(CMD_FG, {5'd0, w.fg_color}, '0, 1'b0);
                end
                if (w.bg_color != trk_bg)
                begin
                    trk_bg = w.bg_color;
                    emit(CMD_BG, {5'd0, w.bg_color}, '0, 1'b0);
                end
            end
            emit(CMD_CHAR, {5'd0, w.glyph}, '0, 1'b1);
        end
    endfunction

    function automatic void note_mismatch(out_t exp_word, out_t got_word, logic orphan);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
        begin
            if (orphan)
                $display("unexpected word: cmd=%0d a=%0d b=%0d last=%0b",
                         got_word.command, got_word.arg_a, got_word.arg_b, got_word.last);
            else
                $display("mismatch: exp %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                         exp_word.command, exp_word.arg_a, exp_word.arg_b, exp_word.last,
                         got_word.command, got_word.arg_a, got_word.arg_b, got_word.last);
        end
    endfunction

    // Sender: pauses twice until every predicted word has been read back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_commands(item);
                void'(cell_queue.pop_front());
                accepted_cells++;
            end
            if (push && full)
            begin
                push <= 1'b1;
            end
            else if (cell_queue.size() != 0
                     && !((accepted_cells == drain_at_a || accepted_cells == drain_at_b)
                          && pending_cmds.size() != 0)
                     && (calm || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                push <= 1'b1;
                item <= cell_queue[0];
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pending_cmds.size() == 0)
                begin
                    note_mismatch(result, result, 1'b1);
                end
                else
                begin
                    want = pending_cmds.pop_front();
                    if (result !== want)
                        note_mismatch(want, result, 1'b0);
                end
            end
            pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        in_t              w;
        int               r;
        int               n_real;
        int               gcol;
        int               grow;
        int               gfg;
        int               gbg;

        cell_queue.push_back(make_word(KIND_FRAME, 0, 0, 0, 0, 0));
        cell_queue.push_back(make_word(KIND_CELL, 0, 0, 0, 0, 8'h41));
        cell_queue.push_back(make_word(KIND_CELL, 1, 0, 0, 0, 8'h42));
        cell_queue.push_back(make_word(KIND_CELL, 5, 0, 255, 0, 8'h43));
        cell_queue.push_back(make_word(KIND_CELL, 2, 0, 255, 255, 8'h44));
        cell_queue.push_back(make_word(KIND_CELL, 3, 7, 1, 0, 8'h45));
        cell_queue.push_back(make_word(KIND_CELL, 4, 2, 1, 0, 8'h46));
        cell_queue.push_back(make_word(KIND_CELL, 100, 100, 9, 9, 0));
        cell_queue.push_back(make_word(KIND_CELL, 5, 2, 0, 0, 8'h47));
        cell_queue.push_back(make_word(KIND_CELL, 4095, 4095, 0, 128, 8'hFF));
        cell_queue.push_back(make_word(KIND_CELL, 0, 4095, 128, 0, 8'h01));
        cell_queue.push_back(make_word(KIND_CELL, 0, 4095, 128, 0, 8'h80));
        cell_queue.push_back(make_word(KIND_CELL, 1, 0, 0, 0, 8'h7F));
        cell_queue.push_back(make_word(KIND_FRAME, 4095, 4095, 255, 255, 255));
        cell_queue.push_back(make_word(KIND_CELL, 4095, 0, 170, 85, 8'h55));
        cell_queue.push_back(make_word(KIND_CELL, 4094, 0, 85, 0, 8'hAA));
        cell_queue.push_back(make_word(KIND_CELL, 4095, 4095, 0, 0, 8'h20));
        cell_queue.push_back(make_word(KIND_CELL, 0, 4095, 0, 0, 8'h21));
        cell_queue.push_back(make_word(KIND_CELL, 0, 0, 0, 1, 8'h22));
        cell_queue.push_back(make_word(KIND_CELL, 1, 0, 0, 1, 0));
        cell_queue.push_back(make_word(KIND_CELL, 1, 0, 0, 1, 8'h23));
        cell_queue.push_back(make_word(KIND_FRAME, 2730, 1365, 170, 85, 170));
        drain_at_a = cell_queue.size();
        drain_at_b = drain_at_a + 380;

        n_real = 0;
        gcol   = 0;
        grow   = 0;
        gfg    = 0;
        gbg    = 0;
        while (n_real < CELL_COUNT)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                w = make_word(KIND_FRAME, $urandom, $urandom, $urandom, $urandom, $urandom);
                gcol = 0;
                grow = 0;
                gfg  = 0;
                gbg  = 0;
            end
            else if (r < 12)
            begin
                w = in_t'({$urandom, $urandom});
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    gcol = gcol + 1;
                end
                else if (r < 80)
                begin
                    grow = grow + 1;
                    if ($urandom_range(0, 1) == 0)
                        gcol = 0;
                end
                else if (r < 88)
                begin
                    gcol = $urandom_range(0, 4095);
                end
                else if (r < 95)
                begin
                    gcol = gcol + 1;
                    grow = $urandom_range(0, 4095);
                end
                else
                begin
                    gcol = $urandom_range(0, 4095);
                    grow = $urandom_range(0, 4095);
                end
                if (gcol > 4095)
                begin
                    gcol = 0;
                    grow = grow + 1;
                end
                grow = grow % 4096;
                if ($urandom_range(0, 99) < 15)
                begin
                    gfg = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
                    gbg = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255);
                end
                w = make_word(KIND_CELL, gcol, grow, gfg, gbg,
                              ($urandom_range(0, 99) < 5) ? 0 : $urandom_range(1, 255));
            end
            if (w.kind == KIND_FRAME || w.glyph != 0)
                n_real++;
            cell_queue.push_back(w);
        end
        total_cells = cell_queue.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cells != total_cells)
            @(posedge clk);
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        mismatch_count = mismatch_count + pending_cmds.size();

        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
